// ===== src/wsdf_pkg.sv =====
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsdf_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 88;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [6:0] LEN_CODE_16 = 7'h7e;
    localparam logic [6:0] LEN_CODE_64 = 7'h7f;

    // one queued result, key byte already selected for the payload lane
    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [2:0]  reserved_bits;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        last_of_frame;
    } wsdf_entry_t;

endpackage

`default_nettype wire

// ===== src/wsdf_front.sv =====
// front end: header parser, mask key capture and payload classification
`default_nettype none

module wsdf_front
    import wsdf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        queue_full,
    output logic             push,
    output wsdf_entry_t      push_entry
);

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_MASK   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_byte_reg, hdr_byte_next;
    logic        mask_flag_reg, mask_flag_next;
    logic        long_len_reg, long_len_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  key_idx_reg, key_idx_next;

    logic accept;
    logic go_after_len;
    logic hdr_done;
    logic [7:0] key_sel;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        case (key_idx_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        hdr_byte_next  = hdr_byte_reg;
        mask_flag_next = mask_flag_reg;
        long_len_next  = long_len_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        remain_next    = remain_reg;
        key_idx_next   = key_idx_reg;
        go_after_len   = 1'b0;
        hdr_done       = 1'b0;
        push           = 1'b0;

        if (accept) begin
            case (phase_reg)
                PH_HDR1: begin
                    mask_flag_next = in_byte[7];
                    cnt_next       = 3'd0;
                    if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
                        len_next      = 64'd0;
                        long_len_next = (in_byte[6:0] == LEN_CODE_64);
                        phase_next    = PH_EXTLEN;
                    end else begin
                        len_next      = {57'd0, in_byte[6:0]};
                        go_after_len  = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    len_next = {len_reg[55:0], in_byte};
                    cnt_next = cnt_reg + 3'd1;
                    if ((long_len_reg && cnt_reg == 3'd7) || (!long_len_reg && cnt_reg == 3'd1)) begin
                        go_after_len = 1'b1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], in_byte};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg >= 3'd3) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_DATA: begin
                    push         = 1'b1;
                    key_idx_next = key_idx_reg + 2'd1;
                    if (remain_reg != 64'd0) begin
                        remain_next = remain_reg - 64'd1;
                    end
                    if (remain_reg <= 64'd1) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    hdr_byte_next  = in_byte;
                    mask_flag_next = 1'b0;
                    long_len_next  = 1'b0;
                    len_next       = 64'd0;
                    cnt_next       = 3'd0;
                    key_next       = 32'd0;
                    remain_next    = 64'd0;
                    key_idx_next   = 2'd0;
                    phase_next     = PH_HDR1;
                end
            endcase
        end

        if (go_after_len) begin
            if (mask_flag_next) begin
                phase_next = PH_MASK;
                cnt_next   = 3'd0;
                key_next   = 32'd0;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            push         = 1'b1;
            remain_next  = len_next;
            key_idx_next = 2'd0;
            phase_next   = (len_next == 64'd0) ? PH_HDR0 : PH_DATA;
        end
    end

    always_comb begin
        push_entry.fin            = hdr_byte_reg[7];
        push_entry.reserved_bits  = hdr_byte_reg[6:4];
        push_entry.opcode         = hdr_byte_reg[3:0];
        push_entry.masked         = mask_flag_next;
        push_entry.payload_length = len_next;
        if (phase_reg == PH_DATA) begin
            push_entry.kind          = KIND_DATA;
            push_entry.raw_byte      = in_byte;
            push_entry.key_byte      = mask_flag_reg ? key_sel : 8'd0;
            push_entry.last_of_frame = (remain_reg <= 64'd1);
        end else begin
            push_entry.kind          = KIND_HEADER;
            push_entry.raw_byte      = 8'd0;
            push_entry.key_byte      = 8'd0;
            push_entry.last_of_frame = (len_next == 64'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            hdr_byte_reg  <= 8'd0;
            mask_flag_reg <= 1'b0;
            long_len_reg  <= 1'b0;
            len_reg       <= 64'd0;
            cnt_reg       <= 3'd0;
            key_reg       <= 32'd0;
            remain_reg    <= 64'd0;
            key_idx_reg   <= 2'd0;
        end else begin
            phase_reg     <= phase_next;
            hdr_byte_reg  <= hdr_byte_next;
            mask_flag_reg <= mask_flag_next;
            long_len_reg  <= long_len_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            remain_reg    <= remain_next;
            key_idx_reg   <= key_idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_data_remain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> remain_reg != 64'd0)
        else $error("payload phase with nothing left to receive");

    a_header_opens_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_entry.kind == KIND_HEADER && !push_entry.last_of_frame
        |=> phase_reg == PH_DATA && key_idx_reg == 2'd0)
        else $error("header result did not open the payload");

    a_last_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_entry.last_of_frame |=> phase_reg == PH_HDR0)
        else $error("frame end did not return to header parsing");
`endif

endmodule

`default_nettype wire

// ===== src/wsdf_queue.sv =====
// small register queue between the parser and the output stage
`default_nettype none

module wsdf_queue
    import wsdf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire wsdf_entry_t push_entry,
    input  wire logic        pop,
    output wsdf_entry_t      head,
    output logic             not_empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsdf_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsdf_back.sv =====
// back end: payload unmasking and the output register
`default_nettype none

module wsdf_back
    import wsdf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire wsdf_entry_t head,
    input  wire logic        not_empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output wsdf_entry_t      out_entry
);

    logic        valid_reg;
    wsdf_entry_t data_reg;
    wsdf_entry_t data_next;

    assign pop = not_empty && (!valid_reg || out_ready);

    always_comb begin
        data_next          = head;
        data_next.raw_byte = head.raw_byte ^ head.key_byte;
        data_next.key_byte = 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_entry = data_reg;

endmodule

`default_nettype wire

// ===== src/websocket_frame_deframer_unmask.sv =====
// WebSocket frame deframer: byte stream in, header and unmasked payload results out
//
// s_ side takes one received byte per beat (s_tdata[7:0]); there is no tlast,
// frames are found from their own headers. m_ side gives one result per beat:
// a header result once the header (two bytes, extended length, mask key) is
// complete, then one result per payload byte with the mask key applied.
// m_tuser is the kind (0 header, 1 payload byte), m_tlast ends the frame; a
// zero-length frame ends on its header result.
// throughput is one byte per cycle while the queue is not full, limited by the
// single parser step in the front end; each result passes through the queue and
// then the output register before it is presented on m_.
// results pass through a QUEUE_DEPTH entry queue and a one-beat output register,
// so while m_tready is low the block keeps taking bytes until that queue and
// the output register are full; s_tready then stays low until the receiver
// takes a beat. Header bytes and mask key bytes give no result of their own.
// synchronous reset clears the parser to the first header byte and empties the
// queue and output register.
`default_nettype none

module websocket_frame_deframer_unmask
    import wsdf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // in_byte[7:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // fin, reserved_bits[3], opcode[4], masked,
                                                  // payload_length[64], data_byte[8], zero pad
    output logic                       m_tuser,   // kind
    output logic                       m_tlast
);

    logic        q_full;
    logic        q_not_empty;
    logic        q_push;
    logic        q_pop;
    wsdf_entry_t q_push_entry;
    wsdf_entry_t q_head;
    wsdf_entry_t res;

    wsdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .queue_full (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    wsdf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    wsdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (res)
    );

    assign m_tdata = {7'd0, res.raw_byte, res.payload_length, res.masked,
                      res.opcode, res.reserved_bits, res.fin};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_frame;

endmodule

`default_nettype wire
